[hw/rtl/pbra_pkg.sv]
// ----------------------------------------------------------------------------
// pbra_pkg
// Shared types and constants for the page bitmap run allocator.
// ----------------------------------------------------------------------------
package pbra_pkg;

  // Bitmap geometry
  localparam int MAX_PAGES   = 4096;
  localparam int WORD_BITS   = 64;
  localparam int NUM_WORDS   = MAX_PAGES / WORD_BITS;
  localparam int WORD_AW     = $clog2(NUM_WORDS);
  localparam int OFS_W       = $clog2(WORD_BITS);
  localparam int CHUNK_BITS  = 8;
  localparam int CHUNKS      = WORD_BITS / CHUNK_BITS;
  localparam int CHUNK_AW    = $clog2(CHUNKS);
  localparam int CHUNK_OW    = $clog2(CHUNK_BITS);

  // Field widths
  localparam int PAGE_W      = 12;
  localparam int CNT_W       = 13;
  localparam int REQ_W       = 2;

  localparam logic [CNT_W-1:0] POOL_RESET = CNT_W'(4096);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TEST  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [PAGE_W-1:0] start_index;
    logic [CNT_W-1:0]  run_length;
  } alloc_req_t;

  typedef struct packed {
    logic              found;
    logic [PAGE_W-1:0] first_page;
    logic              bit_value;
    logic              range_error;
  } alloc_rsp_t;

endpackage

[hw/rtl/pbra_ram.sv]
// ----------------------------------------------------------------------------
// pbra_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pbra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/page_bitmap_run_allocator.sv]
// ----------------------------------------------------------------------------
// page_bitmap_run_allocator
// First-fit contiguous page allocator over a 4096-page occupancy bitmap.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | word
//  --------+-----+---------------------+---------------------------------------
//  in      | in  | in_valid / in_stall | alloc_req_t: req_type, start, length
//  out     | out | out_valid/out_stall | alloc_rsp_t: found, first, bit, error
//  cfg     | in  | cfg_wr_en           | pool_pages (13 bits), write only
//
//  Flow: allocate issues the first read, then scans 64-bit bitmap words from
//  one RAM read port; a word that is all free or all used is taken whole, any
//  other word is scanned 8 pages per cycle, then marking reads and writes
//  each word touched. Free reads and writes each word touched, test reads
//  one word; every request ends in the result stage.
//  Reset: per-word valid flops clear at once, so no clearing sweep; unwritten
//  words read as free. pool_pages resets to 4096.
//  One request is in flight at a time; a result stalled at the output holds
//  the request stage until the output register frees up.
//
module page_bitmap_run_allocator
  import pbra_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  alloc_req_t       in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output alloc_rsp_t       out_data,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  // FSM codes
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ASCAN   = 3'd1;
  localparam logic [2:0] S_MARK_RD = 3'd2;
  localparam logic [2:0] S_MARK_WR = 3'd3;
  localparam logic [2:0] S_TEST    = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [2:0]           state, state_next;
  logic [WORD_AW-1:0]   w, w_next;        // scan word
  logic [CHUNK_AW-1:0]  c, c_next;        // chunk within scan word
  logic [CNT_W-1:0]     run, run_next;    // free run ending at scan point
  logic [CNT_W-1:0]     len, len_next;
  logic [PAGE_W-1:0]    lo, lo_next;      // first page of mark/clear, or test page
  logic [PAGE_W-1:0]    last, last_next;  // last page of mark/clear, inclusive
  logic [WORD_AW-1:0]   mw, mw_next;      // mark/clear word
  logic                 mval, mval_next;  // 1 marks used, 0 clears
  alloc_rsp_t           res, res_next;
  logic [CNT_W-1:0]     pool_pages;
  logic [NUM_WORDS-1:0] vld;              // word written since reset
  logic                 rd_vld;

  // RAM port
  logic                 ram_we, ram_re;
  logic [WORD_AW-1:0]   ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  pbra_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Common terms
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]     lim;
  logic [WORD_BITS-1:0] rdw;
  logic [CNT_W-1:0]     word_start, word_end;
  logic                 out_free;

  // pool_pages saturates at the bitmap size
  assign lim = (pool_pages > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : pool_pages;
  // never-written words read as all free
  assign rdw = rd_vld ? ram_rdata : '0;
  assign word_start = CNT_W'({w, {OFS_W{1'b0}}});
  assign word_end   = word_start + CNT_W'(WORD_BITS);
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != S_IDLE);

  // --------------------------------------------------------------------------
  // Chunk scan: 8 pages per cycle, pages at or past the pool count as used
  // --------------------------------------------------------------------------
  logic [CHUNK_BITS-1:0] chunk;
  logic [CNT_W-1:0]      chunk_base;
  logic [CNT_W-1:0]      ch_run;
  logic                  ch_hit;
  logic [CNT_W-1:0]      ch_end;

  assign chunk      = rdw[c*CHUNK_BITS +: CHUNK_BITS];
  assign chunk_base = CNT_W'({w, c, {CHUNK_OW{1'b0}}});

  always_comb begin
    logic [CNT_W-1:0] idx;
    ch_run = run;
    ch_hit = 1'b0;
    ch_end = '0;
    for (int j = 0; j < CHUNK_BITS; j++) begin
      idx = chunk_base + CNT_W'(j);
      if (!ch_hit) begin
        if (chunk[j] || (idx >= lim)) begin
          ch_run = '0;
        end else begin
          ch_run = ch_run + CNT_W'(1);
          if (ch_run == len) begin
            ch_hit = 1'b1;
            ch_end = idx;
          end
        end
      end
    end
  end

  // Whole-word shortcuts
  logic             wd_free, wd_used, wd_last;
  logic [CNT_W-1:0] run_w, fast_end;

  assign wd_free  = (c == '0) && (rdw == '0) && (word_end <= lim);
  assign wd_used  = (c == '0) && (rdw == ONES);
  assign wd_last  = (w == WORD_AW'(NUM_WORDS - 1)) || (word_end >= lim);
  assign run_w    = run + CNT_W'(WORD_BITS);
  assign fast_end = word_start + (len - run - CNT_W'(1));

  // --------------------------------------------------------------------------
  // Mark / clear mask for word mw
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0] lo_mask, hi_mask, wmask;

  assign lo_mask = (mw == lo[PAGE_W-1:OFS_W]) ? (ONES << lo[OFS_W-1:0]) : ONES;
  assign hi_mask = (mw == last[PAGE_W-1:OFS_W]) ? (ONES >> (~last[OFS_W-1:0])) : ONES;
  assign wmask   = lo_mask & hi_mask;

  // Request decode terms; the free end gets one extra bit so it cannot wrap
  logic [CNT_W:0]   free_sum;
  logic [CNT_W-1:0] free_hi, found_base;

  assign free_sum   = {2'b00, in_data.start_index} + {1'b0, in_data.run_length};
  assign free_hi    = (free_sum > {1'b0, lim}) ? lim : CNT_W'(free_sum);

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_comb begin
    logic [CNT_W-1:0] hit_end;
    hit_end    = wd_free ? fast_end : ch_end;
    found_base = hit_end - len + CNT_W'(1);

    state_next = state;
    w_next     = w;
    c_next     = c;
    run_next   = run;
    len_next   = len;
    lo_next    = lo;
    last_next  = last;
    mw_next    = mw;
    mval_next  = mval;
    res_next   = res;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = w;
    ram_waddr  = mw;
    ram_wdata  = mval ? (rdw | wmask) : (rdw & ~wmask);

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_next = '0;
          case (in_data.req_type)
            REQ_ALLOC: begin
              len_next = in_data.run_length;
              run_next = '0;
              w_next   = '0;
              c_next   = '0;
              if (in_data.run_length == '0) begin
                // empty run: found at page 0, nothing marked
                res_next.found = 1'b1;
                state_next     = S_DONE;
              end else if (lim == '0) begin
                state_next = S_DONE;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = S_ASCAN;
              end
            end
            REQ_FREE: begin
              res_next.range_error = (in_data.run_length != '0) &&
                                     (free_sum > {1'b0, lim});
              lo_next   = in_data.start_index;
              last_next = PAGE_W'(free_hi - CNT_W'(1));
              mw_next   = in_data.start_index[PAGE_W-1:OFS_W];
              mval_next = 1'b0;
              if (CNT_W'(in_data.start_index) < free_hi) begin
                ram_re     = 1'b1;
                ram_raddr  = in_data.start_index[PAGE_W-1:OFS_W];
                state_next = S_MARK_WR;
              end else begin
                state_next = S_DONE;
              end
            end
            REQ_TEST: begin
              lo_next = in_data.start_index;
              if (CNT_W'(in_data.start_index) < lim) begin
                ram_re     = 1'b1;
                ram_raddr  = in_data.start_index[PAGE_W-1:OFS_W];
                state_next = S_TEST;
              end else begin
                res_next.range_error = 1'b1;
                state_next           = S_DONE;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_ASCAN: begin
        if ((wd_free && (run_w >= len)) || (!wd_free && !wd_used && ch_hit)) begin
          // run complete: mark pages base .. hit_end
          res_next.found      = 1'b1;
          res_next.first_page = PAGE_W'(found_base);
          lo_next             = PAGE_W'(found_base);
          last_next           = PAGE_W'(hit_end);
          mw_next             = found_base[PAGE_W-1:OFS_W];
          mval_next           = 1'b1;
          state_next          = S_MARK_RD;
        end else if (wd_free || wd_used || (c == CHUNK_AW'(CHUNKS - 1))) begin
          run_next = wd_free ? run_w : (wd_used ? '0 : ch_run);
          c_next   = '0;
          if (wd_last) begin
            state_next = S_DONE;
          end else begin
            w_next    = w + WORD_AW'(1);
            ram_re    = 1'b1;
            ram_raddr = w + WORD_AW'(1);
          end
        end else begin
          run_next = ch_run;
          c_next   = c + CHUNK_AW'(1);
        end
      end

      S_MARK_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = mw;
        state_next = S_MARK_WR;
      end

      S_MARK_WR: begin
        // write word mw while the next word is read
        ram_we = 1'b1;
        if (mw == last[PAGE_W-1:OFS_W]) begin
          state_next = S_DONE;
        end else begin
          mw_next   = mw + WORD_AW'(1);
          ram_re    = 1'b1;
          ram_raddr = mw + WORD_AW'(1);
        end
      end

      S_TEST: begin
        res_next.bit_value = rdw[lo[OFS_W-1:0]];
        state_next         = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequential
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pool_pages <= POOL_RESET;
      vld        <= '0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        pool_pages <= cfg_wr_data;
      end
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld <= vld[ram_raddr];
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    w    <= w_next;
    c    <= c_next;
    run  <= run_next;
    len  <= len_next;
    lo   <= lo_next;
    last <= last_next;
    mw   <= mw_next;
    mval <= mval_next;
    res  <= res_next;
    if ((state == S_DONE) && out_free) begin
      out_data <= res;
    end
  end

endmodule

[hw/rtl/pbra_checker.sv]
// ----------------------------------------------------------------------------
// pbra_checker
// Port-level checks for the page bitmap run allocator, bound to the top.
// ----------------------------------------------------------------------------
module pbra_checker
  import pbra_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input alloc_rsp_t       out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in flight");

  // an allocate result never carries a range error or a test bit
  a_alloc_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> !out_data.range_error && !out_data.bit_value)
    else $error("allocate result mixed with free/test fields");

  // no start page without a found run
  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.first_page == '0)
    else $error("first_page set without found");

endmodule

bind page_bitmap_run_allocator pbra_checker u_pbra_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_data    (out_data)
);
